@@ rtl/idbs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// idbs_pkg
// Shared widths, operation and status codes, and the control structs that
// pass between the update logic and the top level of the bound store.
// ----------------------------------------------------------------------------
package idbs_pkg;

   localparam int MODE_W   = 3;
   localparam int ID_W     = 8;
   localparam int VAL_W    = 6;
   localparam int STATUS_W = 3;

   typedef enum logic [MODE_W-1:0] {
      MODE_REGISTER      = 3'd0,
      MODE_CLEAR_ALL     = 3'd1,
      MODE_EQUAL         = 3'd2,
      MODE_NOT_EQUAL     = 3'd3,
      MODE_LESS_EQUAL    = 3'd4,
      MODE_GREATER_EQUAL = 3'd5,
      MODE_QUERY         = 3'd6
   } idbs_mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 3'd0,
      STATUS_UNREG   = 3'd1,
      STATUS_ABSENT  = 3'd2,
      STATUS_EMPTY   = 3'd3,
      STATUS_BAD_REG = 3'd4
   } idbs_status_type;

   typedef struct packed {
      logic entry_we;
      logic flag_set;
      logic clear_all;
   } idbs_write_type;

   typedef struct packed {
      logic [VAL_W-1:0] lower;
      logic [VAL_W-1:0] upper;
      logic             changed;
      idbs_status_type  status;
   } idbs_result_type;

endpackage
`default_nettype wire

@@ rtl/idbs_scan.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// idbs_scan
// Finds the lowest and the highest set bit of a domain bitmap by isolating
// the extreme bit and encoding the resulting one-hot word.
// ----------------------------------------------------------------------------
module idbs_scan
   import idbs_pkg::*;
#(
   parameter int WIDTH = 64
) (
   input  wire logic [WIDTH-1:0] bitmap,
   output logic [VAL_W-1:0]      lowest,
   output logic [VAL_W-1:0]      highest
);

   logic [WIDTH-1:0] reversed;
   logic [WIDTH-1:0] low_onehot;
   logic [WIDTH-1:0] high_onehot;
   logic [VAL_W-1:0] high_rev_idx;

   always_comb begin
      for (int i = 0; i < WIDTH; i++) begin
         reversed[i] = bitmap[WIDTH-1-i];
      end
   end

   assign low_onehot  = bitmap & (~bitmap + WIDTH'(1));
   assign high_onehot = reversed & (~reversed + WIDTH'(1));

   always_comb begin
      lowest       = '0;
      high_rev_idx = '0;
      for (int i = 0; i < WIDTH; i++) begin
         if (low_onehot[i]) begin
            lowest = lowest | VAL_W'(i);
         end
         if (high_onehot[i]) begin
            high_rev_idx = high_rev_idx | VAL_W'(i);
         end
      end
   end

   assign highest = VAL_W'(WIDTH-1) - high_rev_idx;

endmodule
`default_nettype wire

@@ rtl/idbs_update.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// idbs_update
// Read-modify-write datapath: from the entry read out of memory and the
// captured transaction, forms the entry to write back, the write controls
// and the result fields.
// ----------------------------------------------------------------------------
module idbs_update
   import idbs_pkg::*;
#(
   parameter int DOMAIN_SIZE = 64
) (
   input  wire logic [MODE_W-1:0]      mode,
   input  wire logic                   id_valid,
   input  wire logic                   registered,
   input  wire logic                   any_registered,
   input  wire logic [VAL_W-1:0]       value,
   input  wire logic [VAL_W-1:0]       upper_value,
   input  wire logic [DOMAIN_SIZE-1:0] bitmap,
   input  wire logic [VAL_W-1:0]       low_bound,
   input  wire logic [VAL_W-1:0]       high_bound,
   output logic [DOMAIN_SIZE-1:0]      new_bitmap,
   output idbs_write_type              wr,
   output idbs_result_type             rsp
);

   localparam logic [VAL_W:0] DOM_LIMIT = (VAL_W+1)'(DOMAIN_SIZE);

   logic [DOMAIN_SIZE-1:0] eq_mask;
   logic [DOMAIN_SIZE-1:0] le_mask;
   logic [DOMAIN_SIZE-1:0] ge_mask;
   logic [DOMAIN_SIZE-1:0] le_upper_mask;
   logic [DOMAIN_SIZE-1:0] ne_bitmap;
   logic [DOMAIN_SIZE-1:0] le_bitmap;
   logic [DOMAIN_SIZE-1:0] ge_bitmap;
   logic [VAL_W-1:0]       ne_lowest;
   logic [VAL_W-1:0]       ne_highest;
   logic                   in_domain;
   logic                   upper_in_range;
   logic                   reg_after;
   logic [VAL_W-1:0]       new_lb;
   logic [VAL_W-1:0]       new_ub;

   always_comb begin
      for (int i = 0; i < DOMAIN_SIZE; i++) begin
         eq_mask[i]       = (VAL_W'(i) == value);
         le_mask[i]       = (VAL_W'(i) <= value);
         ge_mask[i]       = (VAL_W'(i) >= value);
         le_upper_mask[i] = (VAL_W'(i) <= upper_value);
      end
   end

   assign in_domain      = |(bitmap & eq_mask);
   assign upper_in_range = {1'b0, upper_value} < DOM_LIMIT;
   assign ne_bitmap      = bitmap & ~eq_mask;
   assign le_bitmap      = bitmap & le_mask;
   assign ge_bitmap      = bitmap & ge_mask;

   idbs_scan #(
      .WIDTH (DOMAIN_SIZE)
   ) u_scan (
      .bitmap  (ne_bitmap),
      .lowest  (ne_lowest),
      .highest (ne_highest)
   );

   always_comb begin
      new_bitmap   = bitmap;
      new_lb       = low_bound;
      new_ub       = high_bound;
      wr           = '0;
      rsp.changed  = 1'b0;
      rsp.status   = STATUS_OK;
      reg_after    = registered;
      case (mode)
         MODE_REGISTER: begin
            if (!id_valid || registered || (value > upper_value) || !upper_in_range) begin
               rsp.status = STATUS_BAD_REG;
            end else begin
               new_bitmap  = ge_mask & le_upper_mask;
               new_lb      = value;
               new_ub      = upper_value;
               wr.entry_we = 1'b1;
               wr.flag_set = 1'b1;
               rsp.changed = 1'b1;
               reg_after   = 1'b1;
            end
         end
         MODE_CLEAR_ALL: begin
            rsp.changed  = any_registered;
            wr.clear_all = 1'b1;
            reg_after    = 1'b0;
         end
         default: begin
            if (!registered) begin
               rsp.status = STATUS_UNREG;
            end else begin
               case (mode)
                  MODE_EQUAL: begin
                     if (!in_domain) begin
                        rsp.status = STATUS_ABSENT;
                     end else begin
                        rsp.changed = (low_bound != value) || (high_bound != value)
                                      || (bitmap != eq_mask);
                        new_bitmap  = eq_mask;
                        new_lb      = value;
                        new_ub      = value;
                        wr.entry_we = 1'b1;
                     end
                  end
                  MODE_NOT_EQUAL: begin
                     if (in_domain) begin
                        if (ne_bitmap == '0) begin
                           rsp.status = STATUS_EMPTY;
                        end else begin
                           new_bitmap = ne_bitmap;
                           if (low_bound == value) begin
                              new_lb = ne_lowest;
                           end
                           if (high_bound == value) begin
                              new_ub = ne_highest;
                           end
                           wr.entry_we = 1'b1;
                           rsp.changed = 1'b1;
                        end
                     end
                  end
                  MODE_LESS_EQUAL: begin
                     if (value < high_bound) begin
                        if (le_bitmap == '0) begin
                           rsp.status = STATUS_EMPTY;
                        end else begin
                           new_bitmap  = le_bitmap;
                           new_ub      = value;
                           wr.entry_we = 1'b1;
                           rsp.changed = 1'b1;
                        end
                     end
                  end
                  MODE_GREATER_EQUAL: begin
                     if (value > low_bound) begin
                        if ((ge_bitmap == '0) || (value > high_bound)) begin
                           rsp.status = STATUS_EMPTY;
                        end else begin
                           new_bitmap  = ge_bitmap;
                           new_lb      = value;
                           wr.entry_we = 1'b1;
                           rsp.changed = 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      endcase
      rsp.lower = reg_after ? new_lb : '0;
      rsp.upper = reg_after ? new_ub : '0;
   end

endmodule
`default_nettype wire

@@ rtl/integer_domain_bound_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// integer_domain_bound_store
// Per-variable domain bitmap with lower and upper bounds, kept in on-chip
// memories and updated by read-modify-write, one transaction at a time.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   req_mode selects register, clear all, equal, not equal, less-equal,
//   greater-equal or query on variable req_variable_id.
//   The entry is read from memory at the accept edge, updated and written
//   back in the next cycle; the result is registered at the end of that
//   cycle and shown on the rsp_ ports for exactly one cycle with rsp_valid.
//   A new transaction is not taken while one is in progress: the memory
//   read is followed by the update cycle, and the next transaction may be
//   taken in the cycle the result is shown, unless it was a clear all.
//   Clear all additionally sweeps the registration memory, one entry per
//   cycle, holding busy high from its result cycle until the sweep ends.
//   After reset busy stays high for the same sweep.
//   The receiver cannot stall: every result is taken in its strobe cycle.
// ----------------------------------------------------------------------------
module integer_domain_bound_store
   import idbs_pkg::*;
#(
   parameter int NUM_VARIABLES = 256,
   parameter int DOMAIN_SIZE   = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [ID_W-1:0]     req_variable_id,
   input  wire logic [VAL_W-1:0]    req_value,
   input  wire logic [VAL_W-1:0]    req_upper_value,
   output logic                     rsp_valid,
   output logic [VAL_W-1:0]         rsp_lower_out,
   output logic [VAL_W-1:0]         rsp_upper_out,
   output logic                     rsp_changed,
   output logic [STATUS_W-1:0]      rsp_status
);

   localparam int IDX_W   = $clog2(NUM_VARIABLES);
   localparam int ENTRY_W = DOMAIN_SIZE + 2 * VAL_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VARIABLES - 1);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

   state_type             state_ff;
   logic [IDX_W-1:0]      clr_idx_ff;
   logic                  any_reg_ff;
   logic [MODE_W-1:0]     mode_ff;
   logic                  id_valid_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [VAL_W-1:0]      value_ff;
   logic [VAL_W-1:0]      upper_ff;
   logic                  rsp_valid_ff;
   idbs_result_type       rsp_ff;

   logic [ENTRY_W-1:0]    entry_mem [NUM_VARIABLES];
   logic                  flag_mem  [NUM_VARIABLES];
   logic [ENTRY_W-1:0]    entry_rd_ff;
   logic                  flag_rd_ff;

   logic                  accept;
   logic [IDX_W+ID_W-1:0] id_wide;
   logic                  req_id_valid;
   logic [IDX_W-1:0]      rd_idx;
   logic                  exec;
   logic                  entry_wr_en;
   logic                  flag_wr_en;
   logic [IDX_W-1:0]      flag_wr_idx;
   logic                  flag_wr_data;
   logic [DOMAIN_SIZE-1:0] new_bitmap;
   idbs_write_type        wr;
   idbs_result_type       result;
   logic [VAL_W-1:0]      result_lb_wb;
   logic [VAL_W-1:0]      result_ub_wb;

   assign busy         = (state_ff != S_IDLE);
   assign accept       = start && !busy;
   assign id_wide      = {{IDX_W{1'b0}}, req_variable_id};
   assign req_id_valid = int'(req_variable_id) < NUM_VARIABLES;
   assign rd_idx       = req_id_valid ? id_wide[IDX_W-1:0] : '0;
   assign exec         = (state_ff == S_EXEC);

   // entry memory
   assign entry_wr_en = exec && wr.entry_we;

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_rd_ff <= entry_mem[rd_idx];
      end
      if (entry_wr_en) begin
         entry_mem[idx_ff] <= {new_bitmap, result_lb_wb, result_ub_wb};
      end
   end

   // registration memory
   assign flag_wr_en   = (state_ff == S_CLEAR) || (exec && wr.flag_set);
   assign flag_wr_idx  = (state_ff == S_CLEAR) ? clr_idx_ff : idx_ff;
   assign flag_wr_data = (state_ff != S_CLEAR);

   always_ff @(posedge clock) begin
      if (accept) begin
         flag_rd_ff <= flag_mem[rd_idx];
      end
      if (flag_wr_en) begin
         flag_mem[flag_wr_idx] <= flag_wr_data;
      end
   end

   assign result_lb_wb = result.lower;
   assign result_ub_wb = result.upper;

   idbs_update #(
      .DOMAIN_SIZE (DOMAIN_SIZE)
   ) u_update (
      .mode           (mode_ff),
      .id_valid       (id_valid_ff),
      .registered     (id_valid_ff && flag_rd_ff),
      .any_registered (any_reg_ff),
      .value          (value_ff),
      .upper_value    (upper_ff),
      .bitmap         (entry_rd_ff[ENTRY_W-1:2*VAL_W]),
      .low_bound      (entry_rd_ff[2*VAL_W-1:VAL_W]),
      .high_bound     (entry_rd_ff[VAL_W-1:0]),
      .new_bitmap     (new_bitmap),
      .wr             (wr),
      .rsp            (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         any_reg_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= exec;
         case (state_ff)
            S_CLEAR: begin
               if (clr_idx_ff == LAST_IDX) begin
                  clr_idx_ff <= '0;
                  state_ff   <= S_IDLE;
               end else begin
                  clr_idx_ff <= clr_idx_ff + IDX_W'(1);
               end
            end
            S_IDLE: begin
               if (start) begin
                  mode_ff     <= req_mode;
                  id_valid_ff <= req_id_valid;
                  idx_ff      <= rd_idx;
                  value_ff    <= req_value;
                  upper_ff    <= req_upper_value;
                  state_ff    <= S_EXEC;
               end
            end
            S_EXEC: begin
               rsp_ff <= result;
               if (wr.clear_all) begin
                  any_reg_ff <= 1'b0;
                  state_ff   <= S_CLEAR;
               end else begin
                  if (wr.flag_set) begin
                     any_reg_ff <= 1'b1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_CLEAR;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_lower_out = rsp_ff.lower;
   assign rsp_upper_out = rsp_ff.upper;
   assign rsp_changed   = rsp_ff.changed;
   assign rsp_status    = rsp_ff.status;

endmodule
`default_nettype wire
